// ===== rtl/core/assert_macros.svh =====
// assert_macros.svh: concurrent assertion helpers shared by the cell test RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define NCTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed (same-cycle implication)");
// next-cycle implication
`define NCTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed (next-cycle implication)");
`else
`define NCTS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define NCTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/ncts_pkg.sv =====
// ncts_pkg: widths, register codes, payload structs and the rounding search
// step for the navmesh cell test. No dependencies.
package ncts_pkg;

    localparam int COORD_W   = 24;
    localparam int INDEX_W   = 16;
    localparam int LOOK_W    = 16;
    localparam int SLIDE_W   = 16;
    localparam int VERT_W    = 2 * COORD_W;
    localparam int CFG_W     = VERT_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_AB = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_BC = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_CA = 3'd5;

    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int MAG_W     = 15;
    localparam int MAG_LIM   = 2 ** MAG_W;
    localparam int SHIFT_MAX = COORD_W - MAG_W;
    localparam int SHIFT_W   = $clog2(SHIFT_MAX + 1);
    localparam int LSQ_W     = 2 * LOOK_W - 1;
    localparam int L2_W      = LSQ_W + 1;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int PX_W      = MAG_W + LOOK_W + 1;
    localparam int D_W       = PX_W + 1;
    localparam int DM_W      = PX_W;
    localparam int E2_W      = SQ_W + 1;
    localparam int E2SQ_W    = 2 * E2_W;
    localparam int N_W       = MAG_W + DM_W;
    localparam int NL_W      = (N_W + 1) / 2;
    localparam int NH_W      = N_W - NL_W;
    localparam int KL_W      = E2_W;
    localparam int KH_W      = E2SQ_W - KL_W;
    localparam int M_SHIFT   = 30;
    localparam int WIDE_W    = 128;
    localparam int SRCH_W    = 15;
    localparam int SLIDE_ONE = 16384;

    typedef struct packed {
        logic signed [COORD_W-1:0] position_x;
        logic signed [COORD_W-1:0] position_z;
        logic signed [LOOK_W-1:0]  look_x;
        logic signed [LOOK_W-1:0]  look_y;
        logic signed [LOOK_W-1:0]  look_z;
    } in_t;

    typedef struct packed {
        logic                      inside_res;
        logic signed [INDEX_W-1:0] neighbor_index;
        logic signed [SLIDE_W-1:0] slide_x;
        logic signed [SLIDE_W-1:0] slide_z;
    } out_t;

    // result sideband that rides along the search pipeline
    typedef struct packed {
        logic                      in_cell;
        logic signed [INDEX_W-1:0] neighbor;
        logic                      force_zero;
        logic                      neg_x;
        logic                      neg_z;
    } side_t;

    typedef struct packed {
        logic [WIDE_W-1:0] k;
        logic [WIDE_W-1:0] m_x;
        logic [WIDE_W-1:0] m_z;
        side_t             side;
    } srch_in_t;

    typedef struct packed {
        logic [SRCH_W-1:0] lo_x;
        logic [SRCH_W-1:0] lo_z;
        side_t             side;
    } srch_out_t;

    // q = u*u*K, p = u*K with u = 2*lo - 1
    typedef struct packed {
        logic signed [WIDE_W-1:0] q;
        logic signed [WIDE_W-1:0] p;
        logic [SRCH_W-1:0]        lo;
    } chan_t;

    // try setting bit j of lo: accept when (2*lo'-1)^2 * K <= M
    function automatic chan_t srch_step(chan_t c, logic [WIDE_W-1:0] k,
                                        logic [WIDE_W-1:0] m, int j);
        logic signed [WIDE_W-1:0] trial;
        chan_t r;
        trial = c.q + (c.p <<< (j + 2)) + $signed(k << (2 * j + 2));
        r = c;
        if ($unsigned(trial) <= m) begin
            r.q  = trial;
            r.p  = c.p + $signed(k << (j + 1));
            r.lo = c.lo | (SRCH_W'(1) << j);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/ncts_round_search.sv =====
// ncts_round_search: pipelined bit-by-bit rounding search, one result bit per
// stage for both slide components. Depends on ncts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ncts_round_search (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  ncts_pkg::srch_in_t   in_data,
    output logic                 out_valid,
    output ncts_pkg::srch_out_t  out_data
);

    typedef struct packed {
        logic [ncts_pkg::WIDE_W-1:0] k;
        logic [ncts_pkg::WIDE_W-1:0] m_x;
        logic [ncts_pkg::WIDE_W-1:0] m_z;
        ncts_pkg::chan_t             cx;
        ncts_pkg::chan_t             cz;
        ncts_pkg::side_t             side;
    } stage_t;

    stage_t                          stage_reg  [ncts_pkg::SRCH_W];
    stage_t                          stage_next [ncts_pkg::SRCH_W];
    logic [ncts_pkg::SRCH_W-1:0]     valid_reg;
    logic [ncts_pkg::SRCH_W-1:0]     valid_next;
    stage_t                          init;

    always_comb begin
        init.k    = in_data.k;
        init.m_x  = in_data.m_x;
        init.m_z  = in_data.m_z;
        init.side = in_data.side;
        init.cx.q = $signed(in_data.k);
        init.cx.p = -$signed(in_data.k);
        init.cx.lo = '0;
        init.cz   = init.cx;
    end

    // stage s decides bit SRCH_W-1-s
    always_comb begin
        for (int s = 0; s < ncts_pkg::SRCH_W; s++) begin
            stage_t src;
            src = (s == 0) ? init : stage_reg[(s == 0) ? 0 : s - 1];
            stage_next[s]    = src;
            stage_next[s].cx = ncts_pkg::srch_step(src.cx, src.k, src.m_x,
                                                   ncts_pkg::SRCH_W - 1 - s);
            stage_next[s].cz = ncts_pkg::srch_step(src.cz, src.k, src.m_z,
                                                   ncts_pkg::SRCH_W - 1 - s);
        end
    end

    assign valid_next = {valid_reg[ncts_pkg::SRCH_W-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < ncts_pkg::SRCH_W; s++) begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    assign out_valid     = valid_reg[ncts_pkg::SRCH_W-1];
    assign out_data.lo_x = stage_reg[ncts_pkg::SRCH_W-1].cx.lo;
    assign out_data.lo_z = stage_reg[ncts_pkg::SRCH_W-1].cz.lo;
    assign out_data.side = stage_reg[ncts_pkg::SRCH_W-1].side;

    `NCTS_ASSERT_NEXT(a_srch_fill, aclk, aresetn, en && in_valid, valid_reg[0])
    `NCTS_ASSERT_NEXT(a_srch_hold, aclk, aresetn, !en, $stable(valid_reg))
    `NCTS_ASSERT_IMP(a_srch_bound, aclk, aresetn, out_valid && !out_data.side.force_zero, (out_data.lo_x <= ncts_pkg::SLIDE_ONE) && (out_data.lo_z <= ncts_pkg::SLIDE_ONE))

endmodule

// ===== rtl/core/navmesh_cell_test_and_slide.sv =====
// navmesh_cell_test_and_slide: top level of the triangle cell test with wall slide.
// Depends on ncts_pkg, ncts_round_search and assert_macros.svh.
//
// Tests an x-z position against one configured triangle (edges AB, BC, CA in
// order) and, for the first edge that sees the point outside, reports that
// edge's neighbor index and a Q1.14 wall slide vector: the unit edge scaled by
// its dot product with the normalized 3-D look vector, rounded to nearest with
// ties away from zero and saturated to +-16384. Inside points give
// inside_res = 1, neighbor -1 and a zero slide; a zero look vector gives a zero
// slide. Throughput is one transaction per clock unless the pipe stalls. A
// transaction passes through 25 register stages: 9 front stages (edge and
// cross products, first-edge select, 15-bit range reduction, dot product,
// squared terms split into partial products), 15 search stages that each
// settle one bit of the rounded slide magnitude by an exact squared compare,
// and the output register. Input ready drops only when a result waits in the
// output register and the last search stage also holds one. The user must
// write the vertex and neighbor registers through cfg_we/cfg_index/cfg_wdata
// only while no transaction is in flight; the block does not enforce this.
// Indexes past the neighbor CA register are ignored.
`include "assert_macros.svh"

module navmesh_cell_test_and_slide (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ncts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ncts_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ncts_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ncts_pkg::out_t                    m_data
);

    localparam int NFRONT = 9;

    // ---------------- configuration registers ----------------
    logic [ncts_pkg::VERT_W-1:0]         vert_reg [3];
    logic signed [ncts_pkg::INDEX_W-1:0] nb_reg   [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                vert_reg[i] <= '0;
                nb_reg[i]   <= '1;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                ncts_pkg::REG_VERTEX_A:    vert_reg[0] <= cfg_wdata;
                ncts_pkg::REG_VERTEX_B:    vert_reg[1] <= cfg_wdata;
                ncts_pkg::REG_VERTEX_C:    vert_reg[2] <= cfg_wdata;
                ncts_pkg::REG_NEIGHBOR_AB: nb_reg[0] <= cfg_wdata[ncts_pkg::INDEX_W-1:0];
                ncts_pkg::REG_NEIGHBOR_BC: nb_reg[1] <= cfg_wdata[ncts_pkg::INDEX_W-1:0];
                ncts_pkg::REG_NEIGHBOR_CA: nb_reg[2] <= cfg_wdata[ncts_pkg::INDEX_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // whole pipe moves unless the last search stage is full and the result
    // register can't drain
    logic                srch_out_valid;
    ncts_pkg::srch_out_t srch_out;
    logic                en;
    logic [NFRONT:1]     v_reg;
    logic [NFRONT:1]     v_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    ncts_pkg::out_t      m_data_reg;
    ncts_pkg::out_t      m_data_next;

    assign en      = !srch_out_valid || !m_valid_reg || m_ready;
    assign s_ready = en;
    assign v_next  = {v_reg[NFRONT-1:1], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= v_next;
        end
    end

    // ---------------- stage 1: edge vectors and point offsets ----------------
    logic signed [ncts_pkg::COORD_W-1:0] vx [3];
    logic signed [ncts_pkg::COORD_W-1:0] vz [3];
    logic signed [ncts_pkg::DIFF_W-1:0]  s1_ex_reg [3], s1_ex_next [3];
    logic signed [ncts_pkg::DIFF_W-1:0]  s1_ez_reg [3], s1_ez_next [3];
    logic signed [ncts_pkg::DIFF_W-1:0]  s1_dpx_reg [3], s1_dpx_next [3];
    logic signed [ncts_pkg::DIFF_W-1:0]  s1_dpz_reg [3], s1_dpz_next [3];
    logic signed [ncts_pkg::LOOK_W-1:0]  s1_lx_reg, s1_ly_reg, s1_lz_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vx[i] = vert_reg[i][ncts_pkg::VERT_W-1:ncts_pkg::COORD_W];
            vz[i] = vert_reg[i][ncts_pkg::COORD_W-1:0];
        end
        for (int i = 0; i < 3; i++) begin
            s1_ex_next[i]  = ncts_pkg::DIFF_W'(vx[(i == 2) ? 0 : i + 1])
                           - ncts_pkg::DIFF_W'(vx[i]);
            s1_ez_next[i]  = ncts_pkg::DIFF_W'(vz[(i == 2) ? 0 : i + 1])
                           - ncts_pkg::DIFF_W'(vz[i]);
            s1_dpx_next[i] = ncts_pkg::DIFF_W'(s_data.position_x) - ncts_pkg::DIFF_W'(vx[i]);
            s1_dpz_next[i] = ncts_pkg::DIFF_W'(s_data.position_z) - ncts_pkg::DIFF_W'(vz[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s1_ex_reg[i]  <= s1_ex_next[i];
                s1_ez_reg[i]  <= s1_ez_next[i];
                s1_dpx_reg[i] <= s1_dpx_next[i];
                s1_dpz_reg[i] <= s1_dpz_next[i];
            end
            s1_lx_reg <= s_data.look_x;
            s1_ly_reg <= s_data.look_y;
            s1_lz_reg <= s_data.look_z;
        end
    end

    // ---------------- stage 2: cross terms and look squares ----------------
    logic signed [ncts_pkg::PROD_W-1:0]   s2_t1_reg [3], s2_t1_next [3];
    logic signed [ncts_pkg::PROD_W-1:0]   s2_t2_reg [3], s2_t2_next [3];
    logic signed [ncts_pkg::DIFF_W-1:0]   s2_ex_reg [3], s2_ez_reg [3];
    logic signed [2*ncts_pkg::LOOK_W-1:0] lsq_full [3];
    logic [ncts_pkg::LSQ_W-1:0]           s2_lsq_reg [3];
    logic signed [ncts_pkg::LOOK_W-1:0]   s2_lx_reg, s2_lz_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s2_t1_next[i] = ncts_pkg::PROD_W'(s1_ez_reg[i]) * ncts_pkg::PROD_W'(s1_dpx_reg[i]);
            s2_t2_next[i] = ncts_pkg::PROD_W'(s1_ex_reg[i]) * ncts_pkg::PROD_W'(s1_dpz_reg[i]);
        end
        lsq_full[0] = (2*ncts_pkg::LOOK_W)'(s1_lx_reg) * (2*ncts_pkg::LOOK_W)'(s1_lx_reg);
        lsq_full[1] = (2*ncts_pkg::LOOK_W)'(s1_ly_reg) * (2*ncts_pkg::LOOK_W)'(s1_ly_reg);
        lsq_full[2] = (2*ncts_pkg::LOOK_W)'(s1_lz_reg) * (2*ncts_pkg::LOOK_W)'(s1_lz_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s2_t1_reg[i]  <= s2_t1_next[i];
                s2_t2_reg[i]  <= s2_t2_next[i];
                s2_ex_reg[i]  <= s1_ex_reg[i];
                s2_ez_reg[i]  <= s1_ez_reg[i];
                s2_lsq_reg[i] <= lsq_full[i][ncts_pkg::LSQ_W-1:0];
            end
            s2_lx_reg <= s1_lx_reg;
            s2_lz_reg <= s1_lz_reg;
        end
    end

    // ---------------- stage 3: first failing edge ----------------
    logic [2:0]                          outside;
    logic signed [ncts_pkg::CROSS_W-1:0] cross_term [3];
    logic signed [ncts_pkg::DIFF_W-1:0]  sel_ex, sel_ez;
    logic                                s3_inside_reg, s3_inside_next;
    logic signed [ncts_pkg::INDEX_W-1:0] s3_nb_reg, s3_nb_next;
    logic                                s3_sx_reg, s3_sz_reg;
    logic [ncts_pkg::COORD_W-1:0]        s3_amx_reg, s3_amx_next;
    logic [ncts_pkg::COORD_W-1:0]        s3_amz_reg, s3_amz_next;
    logic [ncts_pkg::L2_W-1:0]           s3_l2_reg, s3_l2_next;
    logic signed [ncts_pkg::LOOK_W-1:0]  s3_lx_reg, s3_lz_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cross_term[i] = ncts_pkg::CROSS_W'(s2_t2_reg[i])
                          - ncts_pkg::CROSS_W'(s2_t1_reg[i]);
            outside[i]    = (cross_term[i] > 0);
        end
        s3_inside_next = 1'b1;
        s3_nb_next     = '1;
        sel_ex         = s2_ex_reg[0];
        sel_ez         = s2_ez_reg[0];
        // walk down so the lowest failing edge wins
        for (int i = 2; i >= 0; i--) begin
            if (outside[i]) begin
                s3_inside_next = 1'b0;
                s3_nb_next     = nb_reg[i];
                sel_ex         = s2_ex_reg[i];
                sel_ez         = s2_ez_reg[i];
            end
        end
        s3_amx_next = ncts_pkg::COORD_W'(sel_ex[ncts_pkg::DIFF_W-1] ? -sel_ex : sel_ex);
        s3_amz_next = ncts_pkg::COORD_W'(sel_ez[ncts_pkg::DIFF_W-1] ? -sel_ez : sel_ez);
        s3_l2_next  = ncts_pkg::L2_W'(s2_lsq_reg[0]) + ncts_pkg::L2_W'(s2_lsq_reg[1])
                    + ncts_pkg::L2_W'(s2_lsq_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_inside_reg <= s3_inside_next;
            s3_nb_reg     <= s3_nb_next;
            s3_sx_reg     <= sel_ex[ncts_pkg::DIFF_W-1];
            s3_sz_reg     <= sel_ez[ncts_pkg::DIFF_W-1];
            s3_amx_reg    <= s3_amx_next;
            s3_amz_reg    <= s3_amz_next;
            s3_l2_reg     <= s3_l2_next;
            s3_lx_reg     <= s2_lx_reg;
            s3_lz_reg     <= s2_lz_reg;
        end
    end

    // ---------------- stage 4: range reduction to 15 bits ----------------
    logic [ncts_pkg::COORD_W-1:0]        mag_or;
    logic [ncts_pkg::SHIFT_W-1:0]        shamt;
    logic [ncts_pkg::MAG_W-1:0]          s4_ax_reg, s4_az_reg;
    logic                                s4_sx_reg, s4_sz_reg, s4_inside_reg;
    logic signed [ncts_pkg::INDEX_W-1:0] s4_nb_reg;
    logic [ncts_pkg::L2_W-1:0]           s4_l2_reg;
    logic signed [ncts_pkg::LOOK_W-1:0]  s4_lx_reg, s4_lz_reg;

    always_comb begin
        mag_or = s3_amx_reg | s3_amz_reg;
        shamt  = '0;
        for (int i = 0; i <= ncts_pkg::SHIFT_MAX; i++) begin
            if ((mag_or >> i) >= ncts_pkg::MAG_LIM) begin
                shamt = ncts_pkg::SHIFT_W'(i + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_ax_reg     <= ncts_pkg::MAG_W'(s3_amx_reg >> shamt);
            s4_az_reg     <= ncts_pkg::MAG_W'(s3_amz_reg >> shamt);
            s4_sx_reg     <= s3_sx_reg;
            s4_sz_reg     <= s3_sz_reg;
            s4_inside_reg <= s3_inside_reg;
            s4_nb_reg     <= s3_nb_reg;
            s4_l2_reg     <= s3_l2_reg;
            s4_lx_reg     <= s3_lx_reg;
            s4_lz_reg     <= s3_lz_reg;
        end
    end

    // ---------------- stage 5: dot and length products ----------------
    logic signed [ncts_pkg::PX_W-1:0]    s5_px_reg, s5_pz_reg;
    logic [ncts_pkg::SQ_W-1:0]           s5_ax2_reg, s5_az2_reg;
    logic [ncts_pkg::MAG_W-1:0]          s5_ax_reg, s5_az_reg;
    logic                                s5_sx_reg, s5_sz_reg, s5_inside_reg;
    logic signed [ncts_pkg::INDEX_W-1:0] s5_nb_reg;
    logic [ncts_pkg::L2_W-1:0]           s5_l2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_px_reg  <= ncts_pkg::PX_W'($signed({1'b0, s4_ax_reg}))
                        * ncts_pkg::PX_W'(s4_lx_reg);
            s5_pz_reg  <= ncts_pkg::PX_W'($signed({1'b0, s4_az_reg}))
                        * ncts_pkg::PX_W'(s4_lz_reg);
            s5_ax2_reg <= ncts_pkg::SQ_W'(s4_ax_reg) * ncts_pkg::SQ_W'(s4_ax_reg);
            s5_az2_reg <= ncts_pkg::SQ_W'(s4_az_reg) * ncts_pkg::SQ_W'(s4_az_reg);
            s5_ax_reg     <= s4_ax_reg;
            s5_az_reg     <= s4_az_reg;
            s5_sx_reg     <= s4_sx_reg;
            s5_sz_reg     <= s4_sz_reg;
            s5_inside_reg <= s4_inside_reg;
            s5_nb_reg     <= s4_nb_reg;
            s5_l2_reg     <= s4_l2_reg;
        end
    end

    // ---------------- stage 6: dot product and |e|^2 ----------------
    logic signed [ncts_pkg::D_W-1:0] dot;
    logic [ncts_pkg::DM_W-1:0]       s6_dm_reg;
    logic [ncts_pkg::E2_W-1:0]       s6_e2_reg;
    logic [ncts_pkg::MAG_W-1:0]      s6_ax_reg, s6_az_reg;
    logic [ncts_pkg::L2_W-1:0]       s6_l2_reg;
    ncts_pkg::side_t                 s6_side_reg, s6_side_next;

    always_comb begin
        dot = (s5_sx_reg ? -ncts_pkg::D_W'(s5_px_reg) : ncts_pkg::D_W'(s5_px_reg))
            + (s5_sz_reg ? -ncts_pkg::D_W'(s5_pz_reg) : ncts_pkg::D_W'(s5_pz_reg));
        s6_side_next.in_cell    = s5_inside_reg;
        s6_side_next.neighbor   = s5_nb_reg;
        s6_side_next.force_zero = s5_inside_reg || (s5_l2_reg == '0);
        s6_side_next.neg_x      = s5_sx_reg ^ dot[ncts_pkg::D_W-1];
        s6_side_next.neg_z      = s5_sz_reg ^ dot[ncts_pkg::D_W-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s6_dm_reg   <= ncts_pkg::DM_W'(dot[ncts_pkg::D_W-1] ? -dot : dot);
            s6_e2_reg   <= ncts_pkg::E2_W'(s5_ax2_reg) + ncts_pkg::E2_W'(s5_az2_reg);
            s6_ax_reg   <= s5_ax_reg;
            s6_az_reg   <= s5_az_reg;
            s6_l2_reg   <= s5_l2_reg;
            s6_side_reg <= s6_side_next;
        end
    end

    // ---------------- stage 7: numerators and |e|^4 ----------------
    logic [ncts_pkg::N_W-1:0]    s7_nx_reg, s7_nz_reg;
    logic [ncts_pkg::E2SQ_W-1:0] s7_e2sq_reg;
    logic [ncts_pkg::L2_W-1:0]   s7_l2_reg;
    ncts_pkg::side_t             s7_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s7_nx_reg   <= ncts_pkg::N_W'(s6_ax_reg) * ncts_pkg::N_W'(s6_dm_reg);
            s7_nz_reg   <= ncts_pkg::N_W'(s6_az_reg) * ncts_pkg::N_W'(s6_dm_reg);
            s7_e2sq_reg <= ncts_pkg::E2SQ_W'(s6_e2_reg) * ncts_pkg::E2SQ_W'(s6_e2_reg);
            s7_l2_reg   <= s6_l2_reg;
            s7_side_reg <= s6_side_reg;
        end
    end

    // ---------------- stage 8: partial products ----------------
    localparam int HH_W = 2 * ncts_pkg::NH_W;
    localparam int HL_W = ncts_pkg::NH_W + ncts_pkg::NL_W;
    localparam int LL_W = 2 * ncts_pkg::NL_W;
    localparam int KP_W = ncts_pkg::KL_W + ncts_pkg::L2_W;

    logic [ncts_pkg::NH_W-1:0] hx, hz;
    logic [ncts_pkg::NL_W-1:0] lx_part, lz_part;
    logic [HH_W-1:0]           s8_hhx_reg, s8_hhz_reg;
    logic [HL_W-1:0]           s8_hlx_reg, s8_hlz_reg;
    logic [LL_W-1:0]           s8_llx_reg, s8_llz_reg;
    logic [KP_W-1:0]           s8_khl2_reg, s8_kll2_reg;
    ncts_pkg::side_t           s8_side_reg;

    assign hx      = s7_nx_reg[ncts_pkg::N_W-1:ncts_pkg::NL_W];
    assign lx_part = s7_nx_reg[ncts_pkg::NL_W-1:0];
    assign hz      = s7_nz_reg[ncts_pkg::N_W-1:ncts_pkg::NL_W];
    assign lz_part = s7_nz_reg[ncts_pkg::NL_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            s8_hhx_reg  <= HH_W'(hx) * HH_W'(hx);
            s8_hlx_reg  <= HL_W'(hx) * HL_W'(lx_part);
            s8_llx_reg  <= LL_W'(lx_part) * LL_W'(lx_part);
            s8_hhz_reg  <= HH_W'(hz) * HH_W'(hz);
            s8_hlz_reg  <= HL_W'(hz) * HL_W'(lz_part);
            s8_llz_reg  <= LL_W'(lz_part) * LL_W'(lz_part);
            s8_khl2_reg <= KP_W'(s7_e2sq_reg[ncts_pkg::E2SQ_W-1:ncts_pkg::KL_W])
                         * KP_W'(s7_l2_reg);
            s8_kll2_reg <= KP_W'(s7_e2sq_reg[ncts_pkg::KL_W-1:0]) * KP_W'(s7_l2_reg);
            s8_side_reg <= s7_side_reg;
        end
    end

    // ---------------- stage 9: K = |e|^4 * L2, M = 2^30 * N^2 ----------------
    ncts_pkg::srch_in_t s9_reg, s9_next;

    always_comb begin
        s9_next.k   = (ncts_pkg::WIDE_W'(s8_khl2_reg) << ncts_pkg::KL_W)
                    + ncts_pkg::WIDE_W'(s8_kll2_reg);
        s9_next.m_x = ((ncts_pkg::WIDE_W'(s8_hhx_reg) << (2 * ncts_pkg::NL_W))
                    + (ncts_pkg::WIDE_W'(s8_hlx_reg) << (ncts_pkg::NL_W + 1))
                    + ncts_pkg::WIDE_W'(s8_llx_reg)) << ncts_pkg::M_SHIFT;
        s9_next.m_z = ((ncts_pkg::WIDE_W'(s8_hhz_reg) << (2 * ncts_pkg::NL_W))
                    + (ncts_pkg::WIDE_W'(s8_hlz_reg) << (ncts_pkg::NL_W + 1))
                    + ncts_pkg::WIDE_W'(s8_llz_reg)) << ncts_pkg::M_SHIFT;
        s9_next.side = s8_side_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s9_reg <= s9_next;
        end
    end

    // ---------------- search: one result bit per stage ----------------
    ncts_round_search u_search (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v_reg[NFRONT]),
        .in_data   (s9_reg),
        .out_valid (srch_out_valid),
        .out_data  (srch_out)
    );

    // ---------------- result register ----------------
    logic [ncts_pkg::SLIDE_W-1:0] mag_x, mag_z;

    always_comb begin
        mag_x = (srch_out.lo_x > ncts_pkg::SLIDE_ONE) ? ncts_pkg::SLIDE_W'(ncts_pkg::SLIDE_ONE)
                                                       : ncts_pkg::SLIDE_W'(srch_out.lo_x);
        mag_z = (srch_out.lo_z > ncts_pkg::SLIDE_ONE) ? ncts_pkg::SLIDE_W'(ncts_pkg::SLIDE_ONE)
                                                       : ncts_pkg::SLIDE_W'(srch_out.lo_z);
        m_data_next.inside_res     = srch_out.side.in_cell;
        m_data_next.neighbor_index = srch_out.side.neighbor;
        if (srch_out.side.force_zero) begin
            m_data_next.slide_x = '0;
            m_data_next.slide_z = '0;
        end else begin
            m_data_next.slide_x = srch_out.side.neg_x ? -mag_x : mag_x;
            m_data_next.slide_z = srch_out.side.neg_z ? -mag_z : mag_z;
        end
        if (en && srch_out_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && srch_out_valid) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `NCTS_ASSERT_IMP(a_inside_clean, aclk, aresetn, m_valid && m_data.inside_res, (m_data.slide_x == 0) && (m_data.slide_z == 0) && (m_data.neighbor_index == -1))
    `NCTS_ASSERT_IMP(a_slide_range, aclk, aresetn, m_valid, ($signed(m_data.slide_x) <= 16384) && ($signed(m_data.slide_x) >= -16384) && ($signed(m_data.slide_z) <= 16384) && ($signed(m_data.slide_z) >= -16384))
    `NCTS_ASSERT_IMP(a_stall_cause, aclk, aresetn, !s_ready, m_valid && !m_ready && srch_out_valid)
    `NCTS_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, v_reg[1])

endmodule
